FILE: rtl/core/bmr_pkg.sv
`default_nettype none

package bmr_pkg;

  localparam int MaxWidth   = 128;
  localparam int MaxHeight  = 1024;
  localparam int LaneBits   = 8;
  localparam int NumLanes   = MaxWidth / LaneBits;
  localparam int LaneIdxW   = $clog2(NumLanes);
  localparam int BitIdxW    = $clog2(LaneBits);
  localparam int PosW       = $clog2(MaxWidth);
  localparam int WidthW     = 8;
  localparam int HeightW    = 11;
  localparam int RowW       = 10;
  localparam int StrideW    = LaneIdxW + 1;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 11;

  localparam logic OpByte  = 1'b0;
  localparam logic OpFlush = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgMaskWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaskHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEmpty      = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] mask_byte;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]    rect_x;
    logic [RowW-1:0]    rect_y;
    logic [WidthW-1:0]  rect_width;
    logic [HeightW-1:0] rect_height;
    logic               last_rect;
  } out_item_t;

  typedef struct packed {
    logic                wr_en;
    logic [LaneIdxW-1:0] wr_pos;
    logic [7:0]          wr_byte;
    logic                copy_en;
    logic [StrideW-1:0]  stride;
    logic [WidthW-1:0]   thresh;
    logic [WidthW-1:0]   width;
  } lane_ctrl_t;

  typedef struct packed {
    logic               eq;
    logic               has_set;
    logic [BitIdxW-1:0] set_idx;
    logic               has_clr;
    logic [BitIdxW-1:0] clr_idx;
  } lane_res_t;

  typedef struct packed {
    logic            all_eq;
    logic            set_found;
    logic [PosW-1:0] set_pos;
    logic            clr_found;
    logic [PosW-1:0] clr_pos;
  } merge_res_t;

  function automatic logic [BitIdxW-1:0] first_one(input logic [LaneBits-1:0] v);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int j = LaneBits - 1; j >= 0; j--) begin
      if (v[j]) idx = BitIdxW'(j);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bmr_lane.sv
`default_nettype none

module bmr_lane (
  input  logic                          clk_i,
  input  logic [bmr_pkg::LaneIdxW-1:0]  lane_idx_i,
  input  bmr_pkg::lane_ctrl_t           ctrl_i,
  output bmr_pkg::lane_res_t            res_o
);
  import bmr_pkg::*;

  logic [LaneBits-1:0] grp_q;
  logic [LaneBits-1:0] inc_q;
  logic [LaneBits-1:0] set_cand;
  logic [LaneBits-1:0] clr_cand;
  logic                active;

  assign active = {1'b0, lane_idx_i} < ctrl_i.stride;

  for (genvar j = 0; j < LaneBits; j++) begin : g_pix
    logic [WidthW-1:0] pos;
    assign pos = WidthW'({lane_idx_i, BitIdxW'(j)});
    assign set_cand[j] = grp_q[j] && (pos >= ctrl_i.thresh) && (pos < ctrl_i.width);
    assign clr_cand[j] = (!grp_q[j] || (pos >= ctrl_i.width)) && (pos >= ctrl_i.thresh);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && (ctrl_i.wr_pos == lane_idx_i)) begin
      inc_q <= ctrl_i.wr_byte;
    end
    if (ctrl_i.copy_en && active) begin
      grp_q <= inc_q;
    end
  end

  always_comb begin
    res_o.eq      = !active || (grp_q == inc_q);
    res_o.has_set = |set_cand;
    res_o.set_idx = first_one(set_cand);
    res_o.has_clr = |clr_cand;
    res_o.clr_idx = first_one(clr_cand);
  end

endmodule

`default_nettype wire

FILE: rtl/core/bmr_merge.sv
`default_nettype none

module bmr_merge (
  input  bmr_pkg::lane_res_t  res_i [bmr_pkg::NumLanes],
  output bmr_pkg::merge_res_t res_o
);
  import bmr_pkg::*;

  always_comb begin
    res_o = '0;
    res_o.all_eq = 1'b1;
    for (int i = NumLanes - 1; i >= 0; i--) begin
      res_o.all_eq = res_o.all_eq && res_i[i].eq;
      if (res_i[i].has_set) begin
        res_o.set_found = 1'b1;
        res_o.set_pos   = {LaneIdxW'(i), res_i[i].set_idx};
      end
      if (res_i[i].has_clr) begin
        res_o.clr_found = 1'b1;
        res_o.clr_pos   = {LaneIdxW'(i), res_i[i].clr_idx};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bitmask_to_rectangles.sv
`default_nettype none

// Mask bytes (bit 0 leftmost, rows padded to whole bytes) are stored in 16 byte
// lanes; on a row-ending byte all lanes compare the row to the current group in
// parallel. When a group closes and CfgEmpty is clear, its runs are scanned out
// by a shared start/end search over the lanes: the first run start is found,
// then each run's end is found and its rectangle loaded for output while the
// next start is found; an output stall holds the search. Input is held off
// while a burst is scanned out; the last rectangle may still sit in the output
// register while the next transaction is taken; cfg_we_i writes configuration.

module bitmask_to_rectangles (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bmr_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bmr_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bmr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bmr_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bmr_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCmp   = 3'd1;
  localparam logic [2:0] StStart = 3'd2;
  localparam logic [2:0] StEnd   = 3'd3;
  localparam logic [2:0] StNext  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [WidthW-1:0]   cfg_width_q;
  logic [HeightW-1:0]  cfg_height_q;
  logic                cfg_empty_q;

  logic [HeightW-1:0]  row_cnt_q, row_cnt_d;
  logic [RowW-1:0]     grp_first_q, grp_first_d;
  logic [LaneIdxW-1:0] bp_q, bp_d;
  logic                grp_present_q, grp_present_d;
  logic                copy_pend_q, copy_pend_d;
  logic [RowW-1:0]     emit_y_q, emit_y_d;
  logic [HeightW-1:0]  emit_h_q, emit_h_d;
  logic [WidthW-1:0]   start_q, start_d;
  logic [WidthW-1:0]   end_q, end_d;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [WidthW-1:0]   eff_w;
  logic [HeightW-1:0]  eff_h;
  logic [StrideW-1:0]  stride;
  logic                in_acc;
  logic                row_done;
  logic                out_ld;
  logic                finish;
  logic [WidthW-1:0]   end_pos;
  logic [HeightW-1:0]  grp_rows;

  lane_ctrl_t          lane_ctrl;
  lane_res_t           lane_res [NumLanes];
  merge_res_t          mres;

  always_comb begin
    eff_w = cfg_width_q;
    if (eff_w == '0) eff_w = WidthW'(1);
    if (eff_w > WidthW'(MaxWidth)) eff_w = WidthW'(MaxWidth);
  end

  assign eff_h    = (cfg_height_q > HeightW'(MaxHeight)) ? HeightW'(MaxHeight) : cfg_height_q;
  assign stride   = StrideW'(({1'b0, eff_w} + 9'd7) >> 3);
  assign in_ready_o = (state_q == StIdle);
  assign in_acc   = in_valid_i && in_ready_o;
  assign row_done = ({1'b0, bp_q} + StrideW'(1)) >= stride;
  assign grp_rows = row_cnt_q - HeightW'(grp_first_q);
  assign end_pos  = mres.clr_found ? {1'b0, mres.clr_pos} : WidthW'(MaxWidth);
  assign out_ld   = (state_q == StNext) && (!out_valid_q || out_ready_i);
  assign finish   = ((state_q == StStart) && !mres.set_found) || (out_ld && !mres.set_found);

  always_comb begin
    lane_ctrl.wr_en   = in_acc && (in_data_i.opcode == OpByte) && (row_cnt_q < eff_h);
    lane_ctrl.wr_pos  = bp_q;
    lane_ctrl.wr_byte = in_data_i.mask_byte;
    lane_ctrl.copy_en = ((state_q == StCmp) &&
                         (!grp_present_q || (!mres.all_eq && cfg_empty_q))) ||
                        (finish && copy_pend_q);
    lane_ctrl.stride  = stride;
    lane_ctrl.width   = eff_w;
    case (state_q)
      StEnd:   lane_ctrl.thresh = start_q;
      StNext:  lane_ctrl.thresh = end_q;
      default: lane_ctrl.thresh = '0;
    endcase
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    bmr_lane u_lane (
      .clk_i      (clk_i),
      .lane_idx_i (LaneIdxW'(i)),
      .ctrl_i     (lane_ctrl),
      .res_o      (lane_res[i])
    );
  end

  bmr_merge u_merge (
    .res_i (lane_res),
    .res_o (mres)
  );

  always_comb begin
    state_d       = state_q;
    row_cnt_d     = row_cnt_q;
    grp_first_d   = grp_first_q;
    bp_d          = bp_q;
    grp_present_d = grp_present_q;
    copy_pend_d   = copy_pend_q;
    emit_y_d      = emit_y_q;
    emit_h_d      = emit_h_q;
    start_d       = start_q;
    end_d         = end_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.opcode == OpFlush) begin
            if (grp_present_q && !cfg_empty_q) begin
              emit_y_d    = grp_first_q;
              emit_h_d    = grp_rows;
              copy_pend_d = 1'b0;
              state_d     = StStart;
            end
            row_cnt_d     = '0;
            bp_d          = '0;
            grp_present_d = 1'b0;
          end else if (row_cnt_q < eff_h) begin
            if (row_done) begin
              bp_d    = '0;
              state_d = StCmp;
            end else begin
              bp_d = bp_q + LaneIdxW'(1);
            end
          end
        end
      end
      StCmp: begin
        state_d   = StIdle;
        row_cnt_d = row_cnt_q + HeightW'(1);
        if (!grp_present_q) begin
          grp_first_d   = RowW'(row_cnt_q);
          grp_present_d = 1'b1;
        end else if (!mres.all_eq) begin
          grp_first_d = RowW'(row_cnt_q);
          if (!cfg_empty_q) begin
            emit_y_d    = grp_first_q;
            emit_h_d    = grp_rows;
            copy_pend_d = 1'b1;
            state_d     = StStart;
          end
        end
      end
      StStart: begin
        if (mres.set_found) begin
          start_d = {1'b0, mres.set_pos};
          state_d = StEnd;
        end else begin
          copy_pend_d = 1'b0;
          state_d     = StIdle;
        end
      end
      StEnd: begin
        end_d   = end_pos;
        state_d = StNext;
      end
      StNext: begin
        if (out_ld) begin
          if (mres.set_found) begin
            start_d = {1'b0, mres.set_pos};
            state_d = StEnd;
          end else begin
            copy_pend_d = 1'b0;
            state_d     = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cfg_width_q   <= WidthW'(MaxWidth);
      cfg_height_q  <= HeightW'(MaxHeight);
      cfg_empty_q   <= 1'b0;
      row_cnt_q     <= '0;
      grp_first_q   <= '0;
      bp_q          <= '0;
      grp_present_q <= 1'b0;
      copy_pend_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      row_cnt_q     <= row_cnt_d;
      grp_first_q   <= grp_first_d;
      bp_q          <= bp_d;
      grp_present_q <= grp_present_d;
      copy_pend_q   <= copy_pend_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMaskWidth:  cfg_width_q  <= cfg_data_i[WidthW-1:0];
          CfgMaskHeight: cfg_height_q <= cfg_data_i[HeightW-1:0];
          CfgEmpty:      cfg_empty_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    emit_y_q <= emit_y_d;
    emit_h_q <= emit_h_d;
    start_q  <= start_d;
    end_q    <= end_d;
    if (out_ld) begin
      out_q.rect_x      <= start_q[PosW-1:0];
      out_q.rect_y      <= emit_y_q;
      out_q.rect_width  <= end_q - start_q;
      out_q.rect_height <= emit_h_q;
      out_q.last_rect   <= !mres.set_found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StNext) |-> (end_q > start_q))
    else $error("run end not past run start");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q <= HeightW'(MaxHeight))
    else $error("row counter past maximum height");

  a_group_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_present_q |-> (row_cnt_q >= HeightW'(grp_first_q)))
    else $error("group starts after current row");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.opcode == OpFlush)) |=> ((bp_q == '0) && !grp_present_q))
    else $error("flush did not clear row state");

endmodule

`default_nettype wire

FILE: test/bmr_rect_checker.sv
`timescale 1ns / 100ps

module bmr_rect_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  bmr_pkg::in_item_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  bmr_pkg::out_item_t           out_data_i,
  input  logic                         cfg_we_i,
  input  logic [bmr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bmr_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           pending_o,
  output int                           errors_o
);

  import bmr_pkg::*;

  int         cur_w;
  int         cur_h;
  logic       cur_empty;
  logic [7:0] grp_bytes [16];
  logic [7:0] row_bytes [16];
  int         grp_row0;
  int         row_cnt;
  int         byte_pos;
  logic       grp_valid;
  out_item_t  exp_rects [$];
  int         mismatches;

  function automatic int eff_w();
    int w;
    w = cur_w;
    if (w == 0) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = cur_h;
    if (h > MaxHeight) h = MaxHeight;
    return h;
  endfunction

  // Scan the stored group row and, unless the region is empty, queue one rectangle per run of set pixels.
  function automatic void scan_runs(input int rows);
    int        w;
    int        x;
    int        start;
    int        run_len;
    logic      held;
    out_item_t prev;
    prev = '0;
    held = 1'b0;
    if (!cur_empty) begin
      w = eff_w();
      x = 0;
      while (x < w) begin
        if (!grp_bytes[x / 8][x % 8]) begin
          x++;
        end else begin
          start = x;
          x++;
          while (x < w && grp_bytes[x / 8][x % 8]) x++;
          if (held) exp_rects.push_back(prev);
          run_len          = x - start;
          prev.rect_x      = start[PosW-1:0];
          prev.rect_y      = grp_row0[RowW-1:0];
          prev.rect_width  = run_len[WidthW-1:0];
          prev.rect_height = rows[HeightW-1:0];
          prev.last_rect   = 1'b0;
          held             = 1'b1;
        end
      end
      if (held) begin
        prev.last_rect = 1'b1;
        exp_rects.push_back(prev);
      end
    end
  endfunction

  function automatic void take_item(input in_item_t it);
    int   stride;
    logic differs;
    stride  = (eff_w() + 7) / 8;
    differs = 1'b0;
    if (it.opcode == OpFlush) begin
      if (grp_valid) scan_runs(row_cnt - grp_row0);
      row_cnt   = 0;
      byte_pos  = 0;
      grp_valid = 1'b0;
    end else if (row_cnt < eff_h()) begin
      row_bytes[byte_pos] = it.mask_byte;
      if (byte_pos + 1 < stride) begin
        byte_pos++;
      end else begin
        byte_pos = 0;
        for (int i = 0; i < stride; i++) begin
          if (grp_bytes[i] != row_bytes[i]) differs = 1'b1;
        end
        if (!grp_valid || differs) begin
          if (grp_valid) scan_runs(row_cnt - grp_row0);
          for (int i = 0; i < stride; i++) grp_bytes[i] = row_bytes[i];
          grp_row0  = row_cnt;
          grp_valid = 1'b1;
        end
        row_cnt++;
      end
    end
  endfunction

  function automatic void check_rect(input out_item_t got);
    out_item_t want;
    if (exp_rects.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected rect x=%0d y=%0d w=%0d h=%0d last=%0b", $realtime,
                 got.rect_x, got.rect_y, got.rect_width, got.rect_height, got.last_rect);
      end
    end else begin
      want = exp_rects.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: rect mismatch exp x=%0d y=%0d w=%0d h=%0d last=%0b", $realtime,
                   want.rect_x, want.rect_y, want.rect_width, want.rect_height,
                   want.last_rect);
          $display("%0t:               got x=%0d y=%0d w=%0d h=%0d last=%0b", $realtime,
                   got.rect_x, got.rect_y, got.rect_width, got.rect_height, got.last_rect);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w      = MaxWidth;
      cur_h      = MaxHeight;
      cur_empty  = 1'b0;
      grp_row0   = 0;
      row_cnt    = 0;
      byte_pos   = 0;
      grp_valid  = 1'b0;
      mismatches = 0;
      for (int i = 0; i < 16; i++) begin
        grp_bytes[i] = 8'h00;
        row_bytes[i] = 8'h00;
      end
      exp_rects.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_rect(out_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMaskWidth: begin
            cur_w = int'(cfg_data_i[WidthW-1:0]);
          end
          CfgMaskHeight: begin
            cur_h = int'(cfg_data_i[HeightW-1:0]);
          end
          CfgEmpty: begin
            cur_empty = cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) take_item(in_data_i);
      pending_o <= exp_rects.size();
      errors_o  <= mismatches;
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

  import bmr_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_item_t            in_data_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CfgMaskWidth;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  out_item_t           out_data_o;

  int         pending;
  int         errors;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         sent      = 0;
  int         tb_w      = MaxWidth;
  int         tb_h      = MaxHeight;
  logic [7:0] cur_row [16];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  bitmask_to_rectangles u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  bmr_rect_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send(input logic op, input logic [7:0] b);
    in_item_t it;
    it.opcode    = op;
    it.mask_byte = b;
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic flush();
    send(OpFlush, 8'($urandom_range(255)));
  endtask

  task automatic send_row(input int nb);
    for (int i = 0; i < nb; i++) send(OpByte, cur_row[i]);
  endtask

  // Hold off input until every queued rectangle has been taken, then let the
  // block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_cfg(input int w, input int h, input int e);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgMaskWidth;
    cfg_data_i <= CfgDataW'(w);
    @(posedge clk_i);
    cfg_idx_i  <= CfgMaskHeight;
    cfg_data_i <= CfgDataW'(h);
    @(posedge clk_i);
    cfg_idx_i  <= CfgEmpty;
    cfg_data_i <= CfgDataW'(e);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tb_w = w;
    tb_h = h;
  endtask

  task automatic new_row(input int stride);
    int m;
    m = $urandom_range(9);
    if (m >= 8) begin
      cur_row[$urandom_range(stride - 1)][$urandom_range(7)] ^= 1'b1;
    end else begin
      for (int i = 0; i < 16; i++) begin
        case (m)
          5:       cur_row[i] = 8'h00;
          6:       cur_row[i] = 8'hFF;
          7:       cur_row[i] = 8'($urandom_range(255)) & 8'($urandom_range(255));
          default: cur_row[i] = 8'($urandom_range(255));
        endcase
      end
    end
  endtask

  task automatic random_frame();
    int pick;
    int w;
    int h;
    int stride;
    int hcap;
    int rows;
    if ($urandom_range(99) < 40) begin
      drain();
      pick = $urandom_range(99);
      if (pick < 60)      w = $urandom_range(1, 24);
      else if (pick < 85) w = $urandom_range(25, 128);
      else if (pick < 95) w = $urandom_range(129, 255);
      else                w = 0;
      pick = $urandom_range(99);
      if (pick < 75)      h = $urandom_range(1, 10);
      else if (pick < 85) h = $urandom_range(0, 2);
      else                h = $urandom_range(1024, 2047);
      set_cfg(w, h, ($urandom_range(99) < 10) ? 1 : 0);
    end
    stride = (tb_w == 0) ? 1 : ((tb_w > MaxWidth) ? MaxWidth : tb_w);
    stride = (stride + 7) / 8;
    hcap   = (tb_h > 10) ? 10 : tb_h;
    rows   = $urandom_range(1, hcap + 2);
    for (int r = 0; r < rows; r++) begin
      if (r == 0 || $urandom_range(99) < 45) new_row(stride);
      send_row(stride);
      if ($urandom_range(99) < 4) drain();
    end
    if (stride > 1 && $urandom_range(99) < 15) begin
      new_row(stride);
      send_row($urandom_range(1, stride - 1));
    end
    flush();
  endtask

  initial begin
    int mark;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 32;
    recv_idle = 52;

    // Full width, alternating pixels: the largest burst.
    set_cfg(255, 2047, 0);
    for (int i = 0; i < 16; i++) cur_row[i] = 8'h55;
    send_row(16);
    flush();

    // Merge, a row differing only in padding, a row past the height.
    drain();
    set_cfg(13, 3, 0);
    cur_row[0] = 8'h81;
    cur_row[1] = 8'hFF;
    send_row(2);
    send_row(2);
    cur_row[1] = 8'h1F;
    send_row(2);
    cur_row[0] = 8'h00;
    cur_row[1] = 8'h00;
    send_row(2);
    flush();

    // Width shrinks in the middle of a row.
    send(OpByte, 8'h0F);
    drain();
    set_cfg(3, 3, 0);
    send(OpByte, 8'h05);
    flush();

    // Zero height, then empty region.
    drain();
    set_cfg(0, 0, 0);
    send(OpByte, 8'hFF);
    flush();
    drain();
    set_cfg(0, 5, 1);
    send(OpByte, 8'h01);
    flush();

    // Blank group gives no rectangles.
    drain();
    set_cfg(8, 5, 0);
    send(OpByte, 8'h00);
    send(OpByte, 8'hFF);
    flush();

    for (int p = 0; p < 3; p++) begin
      drain();
      send_idle = (p == 0) ? 32 : ((p == 1) ? 52 : 0);
      recv_idle = (p == 0) ? 52 : ((p == 1) ? 32 : 0);
      mark = sent;
      while (sent - mark < 75) random_frame();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: bitmask_to_rectangles.f
rtl/core/bmr_pkg.sv
rtl/core/bmr_lane.sv
rtl/core/bmr_merge.sv
rtl/core/bitmask_to_rectangles.sv
test/bmr_rect_checker.sv
test/tb.sv
